FILE: rtl/core/uten_pkg.sv
// ----------------------------------------------------------------------------
// uten_pkg: shared types and constants of the UTF-8 text normalizer
// Result record, per-request result bundle, queue sizing and status codes.
// ----------------------------------------------------------------------------
package uten_pkg;

   // A request produces at most this many results: two flushed mark bytes,
   // the current byte and the end-of-file summary.
   localparam int RES_MAX = 4;
   localparam int RES_CW  = $clog2(RES_MAX + 1);
   localparam int RES_IW  = $clog2(RES_MAX);

   // Result queue sizing.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   // Byte values that matter to the scanner.
   localparam logic [7:0] BYTE_EF = 8'hEF;
   localparam logic [7:0] BYTE_BB = 8'hBB;
   localparam logic [7:0] BYTE_BF = 8'hBF;
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   // Summary status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_UTF8  = 2'd1;
   localparam logic [1:0] ST_MIXED_EOL = 2'd2;

   // Line ending style codes.
   localparam logic [1:0] EOL_LF   = 2'd0;
   localparam logic [1:0] EOL_CRLF = 2'd1;
   localparam logic [1:0] EOL_CR   = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       done_res;
      logic [1:0] status;
      logic [1:0] eol_style;
      logic       had_bom;
   } res_type;

   // Results produced by one accepted request, in order, item 0 first.
   typedef struct packed {
      logic [RES_CW-1:0]             count;
      res_type [RES_MAX-1:0]         item;
   } push_type;

endpackage

FILE: rtl/core/uten_scan.sv
// ----------------------------------------------------------------------------
// uten_scan: per-byte scanner
// Holds the mark, UTF-8 and line ending state and turns one request into
// its ordered list of results in a single combinational pass.
// ----------------------------------------------------------------------------
module uten_scan
   import uten_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       has_byte,
   input  logic       end_of_file,
   output push_type   push
);

   typedef enum logic [3:0] {
      BOM_NONE = 4'b0001,
      BOM_EF   = 4'b0010,
      BOM_EFBB = 4'b0100,
      BOM_DONE = 4'b1000
   } bom_phase_type;

   typedef enum logic [2:0] {
      CONT_ANY   = 3'd0,
      CONT_A0_BF = 3'd1,
      CONT_80_9F = 3'd2,
      CONT_90_BF = 3'd3,
      CONT_80_8F = 3'd4
   } cont_range_type;

   typedef struct packed {
      bom_phase_type  phase;
      logic           found;
      logic [1:0]     remaining;
      cont_range_type range;
      logic           err;
      logic           cr_pending;
      logic           seen_lf;
      logic           seen_crlf;
      logic           seen_cr;
   } scan_type;

   typedef struct packed {
      scan_type   s;
      logic       emit;
      logic [7:0] ob;
   } step_type;

   localparam scan_type SCAN_RESET = '{
      phase: BOM_NONE, found: 1'b0, remaining: 2'd0, range: CONT_ANY,
      err: 1'b0, cr_pending: 1'b0, seen_lf: 1'b0, seen_crlf: 1'b0,
      seen_cr: 1'b0
   };

   // One text byte: UTF-8 check, then line ending handling.
   function automatic step_type text_step(input scan_type s_in, input logic [7:0] b);
      step_type   r;
      logic [7:0] lo;
      logic [7:0] hi;
      r      = '{s: s_in, emit: 1'b1, ob: b};
      lo     = 8'h80;
      hi     = 8'hBF;
      if (!r.s.err) begin
         if (r.s.remaining != 2'd0) begin
            case (r.s.range)
               CONT_A0_BF: lo = 8'hA0;
               CONT_80_9F: hi = 8'h9F;
               CONT_90_BF: lo = 8'h90;
               CONT_80_8F: hi = 8'h8F;
               default: ;
            endcase
            if (b >= lo && b <= hi) begin
               r.s.remaining = r.s.remaining - 2'd1;
            end else begin
               r.s.err       = 1'b1;
               r.s.remaining = 2'd0;
            end
            r.s.range = CONT_ANY;
         end else if (b[7]) begin
            case (b) inside
               [8'hC2:8'hDF]: begin
                  r.s.remaining = 2'd1;
                  r.s.range     = CONT_ANY;
               end
               8'hE0: begin
                  r.s.remaining = 2'd2;
                  r.s.range     = CONT_A0_BF;
               end
               8'hED: begin
                  r.s.remaining = 2'd2;
                  r.s.range     = CONT_80_9F;
               end
               [8'hE1:8'hEF]: begin
                  r.s.remaining = 2'd2;
                  r.s.range     = CONT_ANY;
               end
               8'hF0: begin
                  r.s.remaining = 2'd3;
                  r.s.range     = CONT_90_BF;
               end
               [8'hF1:8'hF3]: begin
                  r.s.remaining = 2'd3;
                  r.s.range     = CONT_ANY;
               end
               8'hF4: begin
                  r.s.remaining = 2'd3;
                  r.s.range     = CONT_80_8F;
               end
               default: r.s.err = 1'b1;
            endcase
         end
      end
      // An LF right after a CR was already emitted with the CR.
      if (r.s.cr_pending) begin
         r.s.cr_pending = 1'b0;
         if (b == BYTE_LF) begin
            r.s.seen_crlf = 1'b1;
            r.emit        = 1'b0;
         end else begin
            r.s.seen_cr = 1'b1;
         end
      end
      if (r.emit) begin
         if (b == BYTE_CR) begin
            r.s.cr_pending = 1'b1;
            r.ob           = BYTE_LF;
         end else if (b == BYTE_LF) begin
            r.s.seen_lf = 1'b1;
         end
      end
      return r;
   endfunction

   scan_type scan_ff;
   scan_type scan_in;

   always_comb begin
      scan_type          s;
      step_type          st;
      logic [2:0][7:0]   feed;
      logic [1:0]        nfeed;
      logic [RES_CW-1:0] n;
      logic [1:0]        kinds;
      res_type           sum;
      s     = scan_ff;
      feed  = '0;
      nfeed = 2'd0;
      n     = '0;
      kinds = 2'd0;
      sum   = '0;
      push  = '0;

      // Decide which bytes go to the text path, in order.
      if (has_byte) begin
         case (s.phase)
            BOM_NONE: begin
               if (in_byte == BYTE_EF) begin
                  s.phase = BOM_EF;
               end else begin
                  s.phase     = BOM_DONE;
                  feed[nfeed] = in_byte;
                  nfeed       = nfeed + 2'd1;
               end
            end
            BOM_EF: begin
               if (in_byte == BYTE_BB) begin
                  s.phase = BOM_EFBB;
               end else begin
                  s.phase     = BOM_DONE;
                  feed[0]     = BYTE_EF;
                  feed[1]     = in_byte;
                  nfeed       = 2'd2;
               end
            end
            BOM_EFBB: begin
               s.phase = BOM_DONE;
               if (in_byte == BYTE_BF) begin
                  s.found = 1'b1;
               end else begin
                  feed[0] = BYTE_EF;
                  feed[1] = BYTE_BB;
                  feed[2] = in_byte;
                  nfeed   = 2'd3;
               end
            end
            default: begin
               feed[nfeed] = in_byte;
               nfeed       = nfeed + 2'd1;
            end
         endcase
      end
      if (end_of_file) begin
         case (s.phase)
            BOM_EF: begin
               feed[nfeed] = BYTE_EF;
               nfeed       = nfeed + 2'd1;
            end
            BOM_EFBB: begin
               feed[nfeed] = BYTE_EF;
               nfeed       = nfeed + 2'd1;
               feed[nfeed] = BYTE_BB;
               nfeed       = nfeed + 2'd1;
            end
            default: ;
         endcase
      end

      for (int i = 0; i < 3; i++) begin
         if (i < int'(nfeed)) begin
            st = text_step(s, feed[i]);
            s  = st.s;
            if (st.emit) begin
               push.item[n[RES_IW-1:0]] = '{out_byte: st.ob, out_valid: 1'b1,
                                            done_res: 1'b0, status: ST_OK,
                                            eol_style: EOL_LF, had_bom: 1'b0};
               n = n + RES_CW'(1);
            end
         end
      end

      if (end_of_file) begin
         if (s.cr_pending) begin
            s.seen_cr = 1'b1;
         end
         if (s.remaining != 2'd0) begin
            s.err = 1'b1;
         end
         kinds = {1'b0, s.seen_lf} + {1'b0, s.seen_crlf} + {1'b0, s.seen_cr};
         sum.done_res = 1'b1;
         if (s.err) begin
            sum.status = ST_BAD_UTF8;
         end else if (kinds > 2'd1) begin
            sum.status = ST_MIXED_EOL;
         end else begin
            sum.status    = ST_OK;
            sum.eol_style = s.seen_crlf ? EOL_CRLF : (s.seen_cr ? EOL_CR : EOL_LF);
            sum.had_bom   = s.found;
         end
         push.item[n[RES_IW-1:0]] = sum;
         n = n + RES_CW'(1);
         s = SCAN_RESET;
      end

      push.count = accept ? n : '0;
      scan_in    = accept ? s : scan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SCAN_RESET;
      end else begin
         scan_ff <= scan_in;
      end
   end

endmodule

FILE: rtl/core/uten_queue.sv
// ----------------------------------------------------------------------------
// uten_queue: result queue
// Circular buffer that takes up to four results per cycle and hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module uten_queue
   import uten_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     room,
   output logic     head_valid,
   output res_type  head
);

   res_type [QUEUE_DEPTH-1:0] entries_ff;
   logic [QUEUE_AW-1:0]       wr_ptr_ff;
   logic [QUEUE_AW-1:0]       wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff;
   logic [QUEUE_AW-1:0]       rd_ptr_in;
   logic [QUEUE_CW-1:0]       fill_ff;
   logic [QUEUE_CW-1:0]       fill_in;

   // Room for a full burst of results from the next request.
   assign room       = fill_ff <= QUEUE_CW'(QUEUE_DEPTH - RES_MAX);
   assign head_valid = fill_ff != '0;
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      fill_in   = fill_ff + QUEUE_CW'(push.count) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++) begin
         if (i < int'(push.count)) begin
            entries_ff[wr_ptr_ff + QUEUE_AW'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/core/utf8_text_eol_normalizer_top.sv
// ----------------------------------------------------------------------------
// utf8_text_eol_normalizer_top: UTF-8 validator and line ending normalizer
// Streams a file's bytes, strips a leading byte order mark, checks UTF-8,
// turns CR and CRLF into LF and closes each file with a summary result.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while req_stall is low. Each
// request carries one raw byte of a file (or, with has_byte low, only the
// end-of-file marker). Its results are computed in the cycle the request is
// accepted and enter a small result queue, whose registered head offers them
// on the rsp_ side in order. Most requests give zero or one result; a request
// that disproves or flushes a held byte order mark, or closes a file, gives
// up to four; the response side drains one result per cycle unless stalled.
// The request side stalls only while the queue lacks room for four more
// results, so with a free-flowing consumer the sustained rate is one byte
// per cycle and the stall shows up briefly only after such a multi-result
// request. Text bytes are released before the file's status is known: the
// consumer must discard a file's bytes when its summary (rsp_done_res high)
// reports a nonzero status. On the summary, status 1 means invalid UTF-8 and
// takes priority over status 2, mixed line endings; eol_style and had_bom are
// meaningful only when status is 0. All scanner state returns to its reset
// values after each summary, so files may follow one another back to back.
// ----------------------------------------------------------------------------
module utf8_text_eol_normalizer_top
   import uten_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_has_byte,
   input  logic       req_end_of_file,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_eol_style,
   output logic       rsp_had_bom
);

   logic     accept;
   logic     pop;
   logic     room;
   push_type push;
   res_type  head;

   // A request is taken whenever the queue can absorb its worst-case burst.
   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   uten_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .has_byte    (req_has_byte),
      .end_of_file (req_end_of_file),
      .push        (push)
   );

   uten_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head)
   );

   // The queue head is a register, so the response payload holds while stalled.
   assign rsp_out_byte  = head.out_byte;
   assign rsp_out_valid = head.out_valid;
   assign rsp_done_res  = head.done_res;
   assign rsp_status    = head.status;
   assign rsp_eol_style = head.eol_style;
   assign rsp_had_bom   = head.had_bom;

endmodule

FILE: rtl/core/uten_checker.sv
// ----------------------------------------------------------------------------
// uten_checker: port-level checks of the normalizer
// Watches the top level's ports and flags results that break its rules.
// ----------------------------------------------------------------------------
module uten_checker
   import uten_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_valid,
   input logic       rsp_done_res,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_eol_style,
   input logic       rsp_had_bom
);

   // A text byte never carries summary information.
   text_has_no_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> !rsp_done_res && rsp_status == ST_OK)
      else $error("text byte carries summary fields");

   // A summary carries no text byte.
   summary_has_no_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_out_valid && rsp_out_byte == 8'd0)
      else $error("summary carries a text byte");

   // A failing file reports neither a style nor a mark.
   failed_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status != ST_OK
      |-> rsp_eol_style == EOL_LF && !rsp_had_bom)
      else $error("failing summary reports style or mark");

   // A stalled response stays offered with the same byte.
   stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_done_res))
      else $error("stalled response changed");

endmodule

bind utf8_text_eol_normalizer_top uten_checker u_checker (.*);

FILE: bench/utf8_text_eol_normalizer_check.sv
// ----------------------------------------------------------------------------
// utf8_text_eol_normalizer_check: result predictor and comparator
// Watches both channels of the normalizer. It models the mark stripping,
// UTF-8 checking and line ending rewriting, and compares every response.
// ----------------------------------------------------------------------------
module utf8_text_eol_normalizer_check
   import uten_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_has_byte,
   input  logic       req_end_of_file,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_valid,
   input  logic       rsp_done_res,
   input  logic [1:0] rsp_status,
   input  logic [1:0] rsp_eol_style,
   input  logic       rsp_had_bom,
   output int         fail_count,
   output int         pending,
   output int         results_seen,
   output int         clean_files,
   output int         bad_files,
   output int         mixed_files
);

   typedef enum logic [1:0] {MARK_NONE, MARK_EF, MARK_EF_BB, MARK_DONE} mark_phase_type;
   typedef enum logic [2:0] {
      CONT_ANY, CONT_A0_BF, CONT_80_9F, CONT_90_BF, CONT_80_8F
   } cont_range_type;

   // Scanner state of the file in progress.
   mark_phase_type mark_phase;
   logic           mark_removed;
   logic [1:0]     cont_left;
   cont_range_type cont_range;
   logic           bad_utf8;
   logic           cr_held;
   logic           saw_lf;
   logic           saw_crlf;
   logic           saw_cr;

   res_type due_results[$];
   int      mismatches;
   int      n_results;
   int      n_clean;
   int      n_bad;
   int      n_mixed;

   task automatic clear_scanner();
      mark_phase   = MARK_NONE;
      mark_removed = 1'b0;
      cont_left    = 2'd0;
      cont_range   = CONT_ANY;
      bad_utf8     = 1'b0;
      cr_held      = 1'b0;
      saw_lf       = 1'b0;
      saw_crlf     = 1'b0;
      saw_cr       = 1'b0;
   endtask

   task automatic scan_utf8(input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (bad_utf8) begin
         // The error is sticky; nothing more to track in this file.
      end else if (cont_left != 2'd0) begin
         case (cont_range)
            CONT_A0_BF: lo = 8'hA0;
            CONT_80_9F: hi = 8'h9F;
            CONT_90_BF: lo = 8'h90;
            CONT_80_8F: hi = 8'h8F;
            default: ;
         endcase
         if (b >= lo && b <= hi) begin
            cont_left = cont_left - 2'd1;
         end else begin
            bad_utf8  = 1'b1;
            cont_left = 2'd0;
         end
         cont_range = CONT_ANY;
      end else if (b >= 8'h80) begin
         if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_left  = 2'd1;
            cont_range = CONT_ANY;
         end else if (b == 8'hE0) begin
            cont_left  = 2'd2;
            cont_range = CONT_A0_BF;
         end else if (b == 8'hED) begin
            cont_left  = 2'd2;
            cont_range = CONT_80_9F;
         end else if (b >= 8'hE1 && b <= 8'hEF) begin
            cont_left  = 2'd2;
            cont_range = CONT_ANY;
         end else if (b == 8'hF0) begin
            cont_left  = 2'd3;
            cont_range = CONT_90_BF;
         end else if (b >= 8'hF1 && b <= 8'hF3) begin
            cont_left  = 2'd3;
            cont_range = CONT_ANY;
         end else if (b == 8'hF4) begin
            cont_left  = 2'd3;
            cont_range = CONT_80_8F;
         end else begin
            bad_utf8 = 1'b1;
         end
      end
   endtask

   task automatic push_text(input logic [7:0] b);
      res_type r;
      r           = '0;
      r.out_byte  = b;
      r.out_valid = 1'b1;
      due_results.push_back(r);
   endtask

   // One text byte after mark handling: check it, then rewrite line endings.
   // A CR is emitted as LF at once, so an LF right after it is swallowed.
   task automatic emit_text(input logic [7:0] b);
      logic swallow;
      swallow = 1'b0;
      scan_utf8(b);
      if (cr_held) begin
         cr_held = 1'b0;
         if (b == BYTE_LF) begin
            saw_crlf = 1'b1;
            swallow  = 1'b1;
         end else begin
            saw_cr = 1'b1;
         end
      end
      if (!swallow) begin
         if (b == BYTE_CR) begin
            cr_held = 1'b1;
            push_text(BYTE_LF);
         end else begin
            if (b == BYTE_LF) saw_lf = 1'b1;
            push_text(b);
         end
      end
   endtask

   task automatic close_file();
      res_type r;
      int      kinds;
      if (mark_phase == MARK_EF) begin
         emit_text(BYTE_EF);
      end else if (mark_phase == MARK_EF_BB) begin
         emit_text(BYTE_EF);
         emit_text(BYTE_BB);
      end
      if (cr_held) saw_cr = 1'b1;
      if (cont_left != 2'd0) bad_utf8 = 1'b1;
      kinds      = int'(saw_lf) + int'(saw_crlf) + int'(saw_cr);
      r          = '0;
      r.done_res = 1'b1;
      if (bad_utf8) begin
         r.status = ST_BAD_UTF8;
         n_bad++;
      end else if (kinds > 1) begin
         r.status = ST_MIXED_EOL;
         n_mixed++;
      end else begin
         r.status    = ST_OK;
         r.eol_style = saw_crlf ? EOL_CRLF : (saw_cr ? EOL_CR : EOL_LF);
         r.had_bom   = mark_removed;
         n_clean++;
      end
      due_results.push_back(r);
      clear_scanner();
   endtask

   task automatic normalize_request(input logic [7:0] b, input logic has,
                                    input logic eof);
      if (has) begin
         case (mark_phase)
            MARK_NONE: begin
               if (b == BYTE_EF) begin
                  mark_phase = MARK_EF;
               end else begin
                  mark_phase = MARK_DONE;
                  emit_text(b);
               end
            end
            MARK_EF: begin
               if (b == BYTE_BB) begin
                  mark_phase = MARK_EF_BB;
               end else begin
                  mark_phase = MARK_DONE;
                  emit_text(BYTE_EF);
                  emit_text(b);
               end
            end
            MARK_EF_BB: begin
               mark_phase = MARK_DONE;
               if (b == BYTE_BF) begin
                  mark_removed = 1'b1;
               end else begin
                  emit_text(BYTE_EF);
                  emit_text(BYTE_BB);
                  emit_text(b);
               end
            end
            default: emit_text(b);
         endcase
      end
      if (eof) close_file();
   endtask

   task automatic compare_result();
      res_type e;
      n_results++;
      if (due_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d arrived with nothing outstanding: byte %h done %b",
                     n_results, rsp_out_byte, rsp_done_res);
      end else begin
         e = due_results.pop_front();
         if (rsp_out_byte !== e.out_byte || rsp_out_valid !== e.out_valid ||
             rsp_done_res !== e.done_res || rsp_status !== e.status ||
             rsp_eol_style !== e.eol_style || rsp_had_bom !== e.had_bom) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result %0d wrong: expected byte %h valid %b done %b ",
                         "status %0d eol %0d bom %b, got byte %h valid %b done %b ",
                         "status %0d eol %0d bom %b"},
                        n_results, e.out_byte, e.out_valid, e.done_res, e.status,
                        e.eol_style, e.had_bom, rsp_out_byte, rsp_out_valid,
                        rsp_done_res, rsp_status, rsp_eol_style, rsp_had_bom);
         end
      end
   endtask

   // Responses are checked before the request of the same edge is predicted,
   // so a result can never be matched against an expectation made too late.
   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result();
         if (req_valid && !req_stall)
            normalize_request(req_in_byte, req_has_byte, req_end_of_file);
      end
      fail_count   <= mismatches;
      pending      <= due_results.size();
      results_seen <= n_results;
      clean_files  <= n_clean;
      bad_files    <= n_bad;
      mixed_files  <= n_mixed;
   end

endmodule

FILE: bench/utf8_text_eol_normalizer_top_test.sv
// ----------------------------------------------------------------------------
// utf8_text_eol_normalizer_top_test: stimulus and verdict for the normalizer
// Feeds directed and random files through the block with random gaps and
// stalls on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module utf8_text_eol_normalizer_top_test
   import uten_pkg::*;
();

   // Stop the random part once this many requests have gone in (directed
   // requests included). No-op requests do not count.
   localparam int TOTAL_ITEMS  = 410;
   // The receiver freezes once, after this many results, for this long.
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 16;

   // Kinds of character the random text generator can append.
   typedef enum int {TOK_TEXT, TOK_EOL, TOK_TWO, TOK_THREE, TOK_FOUR, TOK_LOW} token_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_has_byte;
   logic       req_end_of_file;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_done_res;
   logic [1:0] rsp_status;
   logic [1:0] rsp_eol_style;
   logic       rsp_had_bom;

   int fail_count;
   int pending;
   int results_seen;
   int clean_files;
   int bad_files;
   int mixed_files;

   // Bytes of the file currently being built, and run statistics.
   logic [7:0] file_bytes[$];
   int         items_sent;
   int         files_sent;
   int         directed_items;
   int         rsp_taken;
   bit         sender_calm;
   bit         rsp_calm;
   bit         hold_done;
   logic       long_hold;

   utf8_text_eol_normalizer_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_has_byte    (req_has_byte),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .rsp_eol_style   (rsp_eol_style),
      .rsp_had_bom     (rsp_had_bom)
   );

   // The checker sees exactly what the block sees and hands back its counts.
   utf8_text_eol_normalizer_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_has_byte    (req_has_byte),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .rsp_eol_style   (rsp_eol_style),
      .rsp_had_bom     (rsp_had_bom),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_seen    (results_seen),
      .clean_files     (clean_files),
      .bad_files       (bad_files),
      .mixed_files     (mixed_files)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle cycles before the next request or the next result. Half the
   // draws are zero so back-to-back traffic is common; a calm side never
   // idles, which gives stretches of full-rate streaming.
   function automatic int draw_wait(input bit calm);
      int pick;
      pick = $urandom_range(0, 9);
      if (calm || pick < 5) return 0;
      if (pick < 8) return $urandom_range(1, 3);
      return $urandom_range(4, 17);
   endfunction

   // Offers one request starting at a falling edge and returns at the
   // falling edge after it was taken. Valid is only dropped when a gap is
   // actually drawn, so a back-to-back request never toggles it.
   task automatic send_request(input logic [7:0] b, input logic has, input logic eof);
      int gap;
      gap = long_hold ? 0 : draw_wait(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_has_byte    <= has;
      req_end_of_file <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (has || eof) items_sent++;
      @(negedge clock);
   endtask

   // Sends file_bytes as one file. The last byte carries the end flag,
   // unless a separate byte-less end marker is asked for (or the file is
   // empty). Now and then a byte-less, non-final request is slipped in:
   // the block must ignore it.
   task automatic send_file(input bit end_marker);
      int last;
      last = file_bytes.size() - 1;
      for (int i = 0; i <= last; i++) begin
         if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
         send_request(file_bytes[i], 1'b1, (i == last) && !end_marker);
      end
      if (end_marker || last < 0) send_request(8'($urandom), 1'b0, 1'b1);
      files_sent++;
   endtask

   // Appends one character to the file: printable or low ASCII, a line
   // ending in the file's style (sometimes another one), or a well-formed
   // multi-byte sequence that respects the narrow second-byte ranges after
   // E0, ED, F0 and F4.
   task automatic add_token(input logic [1:0] style);
      token_type  kind;
      int         pick;
      logic [1:0] eol;
      logic [7:0] lead;
      pick = $urandom_range(0, 7);
      kind = (pick > 5) ? TOK_TEXT : token_type'(pick);
      case (kind)
         TOK_TEXT: file_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
         TOK_LOW:  file_bytes.push_back(8'($urandom_range(0, 127)));
         TOK_EOL: begin
            eol = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 2)) : style;
            if (eol != EOL_LF) file_bytes.push_back(BYTE_CR);
            if (eol != EOL_CR) file_bytes.push_back(BYTE_LF);
         end
         TOK_TWO: begin
            file_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         TOK_THREE: begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            file_bytes.push_back(lead);
            if (lead == 8'hE0)
               file_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
            else if (lead == 8'hED)
               file_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
            else
               file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         default: begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            file_bytes.push_back(lead);
            if (lead == 8'hF0)
               file_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
            else if (lead == 8'hF4)
               file_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
            else
               file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
      endcase
   endtask

   // Builds one random file. Most files are well-formed text, half of them
   // with a byte order mark and each with one line ending style; some of
   // those get their last byte cut off or one byte overwritten. The rest
   // are empty files or raw noise, often opening with a partial mark.
   task automatic build_file(output bit end_marker);
      int         shape;
      int         pos;
      logic [1:0] style;
      file_bytes.delete();
      end_marker = ($urandom_range(0, 9) == 0);
      shape      = $urandom_range(0, 99);
      if (shape < 5) begin
         end_marker = 1'b1;
      end else if (shape < 22) begin
         case ($urandom_range(0, 2))
            1: file_bytes.push_back(BYTE_EF);
            2: begin
               file_bytes.push_back(BYTE_EF);
               file_bytes.push_back(BYTE_BB);
            end
            default: file_bytes.push_back(8'($urandom));
         endcase
         repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
      end else begin
         if ($urandom_range(0, 1)) begin
            file_bytes.push_back(BYTE_EF);
            file_bytes.push_back(BYTE_BB);
            file_bytes.push_back(BYTE_BF);
         end
         style = 2'($urandom_range(0, 2));
         repeat ($urandom_range(1, 10)) add_token(style);
         if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, file_bytes.size() - 1);
            if ($urandom_range(0, 1)) void'(file_bytes.pop_back());
            else file_bytes[pos] = 8'($urandom);
         end
      end
   endtask

   // Result side. Each result waits a drawn number of stall cycles. Once in
   // the run, after HOLD_AFTER results, the receiver stalls for a long
   // stretch while the sender keeps offering back to back, so the result
   // queue fills and the block has to stall its request side.
   initial begin
      int n;
      rsp_stall = 1'b0;
      rsp_taken = 0;
      rsp_calm  = 1'b0;
      hold_done = 1'b0;
      long_hold = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_taken == HOLD_AFTER && !hold_done) begin
            hold_done = 1'b1;
            long_hold <= 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold <= 1'b0;
         end else begin
            n = draw_wait(rsp_calm);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         // With stall low, the next edge with valid high takes the result.
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsp_taken++;
         if ($urandom_range(0, 39) == 0) rsp_calm = ~rsp_calm;
         @(negedge clock);
      end
   end

   // Request side and verdict.
   initial begin
      bit end_marker;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_in_byte     = 8'h00;
      req_has_byte    = 1'b0;
      req_end_of_file = 1'b0;
      items_sent      = 0;
      files_sent      = 0;
      sender_calm     = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed files. An empty file closed by a byte-less end marker.
      file_bytes.delete();
      send_file(1'b1);
      // A full mark, text and a CRLF: clean, CRLF style, mark flagged.
      file_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF, 8'h41, BYTE_CR, BYTE_LF};
      send_file(1'b0);
      // A file that ends on a half mark: both held bytes are flushed at the
      // end, and the three-byte sequence they start is left unfinished.
      file_bytes = '{BYTE_EF, BYTE_BB};
      send_file(1'b0);
      // A mark disproved by the final byte: two flushed bytes, the byte
      // itself and the summary make the largest burst of results.
      file_bytes = '{BYTE_EF, BYTE_BB, 8'h41};
      send_file(1'b0);
      // A lone CR, an ignored byte-less request, an LF, the lowest byte and
      // an invalid lead byte: status must be invalid UTF-8, not mixed.
      send_request(BYTE_CR, 1'b1, 1'b0);
      send_request(8'h5A, 1'b0, 1'b0);
      file_bytes = '{8'h41, BYTE_LF, 8'h00, 8'hFF};
      send_file(1'b0);
      // The largest code point, the smallest legal E0 sequence, and a CR on
      // the final byte that is only recognized as lone at end of file.
      file_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE0, 8'hA0, 8'h80, BYTE_CR};
      send_file(1'b0);
      directed_items = items_sent;

      // Random files until the request budget is used up. A quarter of the
      // files go in with no gaps at all.
      while (items_sent < TOTAL_ITEMS) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         build_file(end_marker);
         send_file(end_marker);
      end
      req_valid <= 1'b0;

      // Let the outstanding results drain, then keep watching the block in case
      // it emits something it should not.
      for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending != 0) $display("%0d expected results never arrived", pending);

      $display("Sent %0d requests (%0d directed) in %0d files, with one %0d-cycle result hold.",
               items_sent, directed_items, files_sent, HOLD_CYCLES);
      $display("Checked %0d results; files: %0d clean, %0d invalid UTF-8, %0d mixed endings.",
               results_seen, clean_files, bad_files, mixed_files);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog. Its limit lies far beyond what a correct run needs, even with every
   // request giving four results and both sides at their longest waits; a run
   // that reaches it is judged a mismatch.
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
